// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/core/tpag_pkg.sv -----
package tpag_pkg;

    localparam int NUM_AXES = 4;
    // Leading NUM_AXES - MAX_RANK input axes always count as size 1.
    localparam int MAX_RANK = 4;

    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int IDX_W    = 48;
    localparam int BYTE_W   = 51;
    localparam int BYTES_W  = 4;
    localparam int ORDER_W  = 8;
    localparam int STRIDE_W = 37;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int Q_DEPTH  = 4;

    typedef enum logic [2:0] {
        REG_DIM0       = 3'd0,
        REG_DIM1       = 3'd1,
        REG_DIM2       = 3'd2,
        REG_DIM3       = 3'd3,
        REG_AXIS_ORDER = 3'd4,
        REG_ELEM_BYTES = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0]  coord;
        logic [IDX_W-1:0]                  dst;
        logic                              last;
    } t_entry;

    // Geometry derived from the registers, indexed by output axis.
    typedef struct packed {
        logic [NUM_AXES-1:0][DIM_W-1:0]    odim;
        logic [NUM_AXES-1:0][STRIDE_W-1:0] ostride;
        logic [BYTES_W-1:0]                bytes;
        logic                              busy;
    } t_geom;

endpackage

// ----- rtl/core/tensor_permute_address_gen.sv -----
// Permute address generator: each input beat advances one element along the
// output tensor in row-major order and returns one output beat with its
// destination index, its source index in the input tensor, both scaled to byte
// offsets, and a flag on the final element; restart set in a beat starts over
// at element zero. It sustains one beat per cycle while the queue has room and no
// register write is settling; an input beat passes the entry queue and the back-end
// pipeline before it reaches the output, and up to eight beats may be in flight.
// After a register write the input is held off while the strides are recomputed
// by a two-stage multiplier chain.
module tensor_permute_address_gen #(
    parameter int QUEUE_DEPTH = tpag_pkg::Q_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpag_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpag_pkg::DATA_W-1:0]  pwdata,
    output logic [tpag_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tpag_pkg::IDX_W-1:0]   o_dst_index,
    output logic [tpag_pkg::IDX_W-1:0]   o_src_index,
    output logic [tpag_pkg::BYTE_W-1:0]  o_dst_byte_offset,
    output logic [tpag_pkg::BYTE_W-1:0]  o_src_byte_offset,
    output logic                         o_last
);
    import tpag_pkg::*;

    t_geom  w_geom;
    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;
    logic   w_back_ready;

    assign pready = 1'b1;

    tpag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_geom  (w_geom)
    );

    tpag_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .i_geom     (w_geom),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    tpag_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    assign w_pop = !w_empty && w_back_ready;

    tpag_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (!w_empty),
        .o_ready           (w_back_ready),
        .i_entry           (w_head),
        .i_geom            (w_geom),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_dst_index       (o_dst_index),
        .o_src_index       (o_src_index),
        .o_dst_byte_offset (o_dst_byte_offset),
        .o_src_byte_offset (o_src_byte_offset),
        .o_last            (o_last)
    );

`include "assert_macros.svh"

    `ASSERT_NEVER(a_queue_overflow, w_push && w_full, "push into a full queue")
    `ASSERT_NEVER(a_queue_underflow, w_pop && w_empty, "pop from an empty queue")
    `ASSERT_AT_CLK(a_cfg_hold, (psel && penable && pwrite) |=> !o_in_ready, "input while settling")

endmodule

// ----- rtl/core/tpag_cfg.sv -----
module tpag_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpag_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpag_pkg::DATA_W-1:0]  pwdata,
    output logic [tpag_pkg::DATA_W-1:0]  prdata,
    output tpag_pkg::t_geom              o_geom
);
    import tpag_pkg::*;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'd228;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 4'd4;
    localparam logic [DIM_W-1:0]   DIM_MAX     = 13'd4096;
    localparam logic [2:0]         FIRST_AXIS  = 3'(NUM_AXES - MAX_RANK);

    logic [NUM_AXES-1:0][DIM_W-1:0]    r_dim;
    logic [ORDER_W-1:0]                r_order;
    logic [BYTES_W-1:0]                r_bytes;
    logic [DIM_W-1:0]                  r_stride2;
    logic [2*DIM_W-2:0]                r_stride1;
    logic [STRIDE_W-1:0]               r_stride0;
    logic [1:0]                        r_settle;

    logic                              w_wr;
    logic [2:0]                        w_index;
    logic [NUM_AXES-1:0][DIM_W-1:0]    w_eff;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] w_stride;
    logic [BYTES_W-1:0]                w_bytes;
    logic [2*DIM_W-1:0]                w_prod1;
    logic [STRIDE_W:0]                 w_prod0;

    assign w_wr    = psel && penable && pwrite;
    assign w_index = paddr[ADDR_W-1:2];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (3'(a) < FIRST_AXIS) begin
                w_eff[a] = 13'd1;
            end else if (r_dim[a] == '0) begin
                w_eff[a] = 13'd1;
            end else if (r_dim[a] > DIM_MAX) begin
                w_eff[a] = DIM_MAX;
            end else begin
                w_eff[a] = r_dim[a];
            end
        end
    end

    always_comb begin
        if (r_bytes == '0) begin
            w_bytes = 4'd1;
        end else if (r_bytes > 4'd8) begin
            w_bytes = 4'd8;
        end else begin
            w_bytes = r_bytes;
        end
    end

    // Row-major strides are recomputed after a write by a registered chain, one
    // multiplier per stage.
    assign w_prod1 = w_eff[2] * w_eff[3];
    assign w_prod0 = r_stride1 * w_eff[1];

    assign w_stride[0] = r_stride0;
    assign w_stride[1] = STRIDE_W'(r_stride1);
    assign w_stride[2] = STRIDE_W'(r_stride2);
    assign w_stride[3] = STRIDE_W'(1);

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            o_geom.odim[j]    = w_eff[r_order[2*j +: 2]];
            o_geom.ostride[j] = w_stride[r_order[2*j +: 2]];
        end
        o_geom.bytes = w_bytes;
        o_geom.busy  = (r_settle != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim     <= {NUM_AXES{13'd1}};
            r_order   <= ORDER_RESET;
            r_bytes   <= BYTES_RESET;
            r_stride2 <= 13'd1;
            r_stride1 <= 25'd1;
            r_stride0 <= 37'd1;
            r_settle  <= 2'd0;
        end else begin
            r_stride2 <= w_eff[3];
            r_stride1 <= w_prod1[2*DIM_W-2:0];
            r_stride0 <= w_prod0[STRIDE_W-1:0];
            if (w_wr) begin
                r_settle <= 2'd2;
                case (w_index)
                    REG_DIM0:       r_dim[0] <= pwdata[DIM_W-1:0];
                    REG_DIM1:       r_dim[1] <= pwdata[DIM_W-1:0];
                    REG_DIM2:       r_dim[2] <= pwdata[DIM_W-1:0];
                    REG_DIM3:       r_dim[3] <= pwdata[DIM_W-1:0];
                    REG_AXIS_ORDER: r_order  <= pwdata[ORDER_W-1:0];
                    REG_ELEM_BYTES: r_bytes  <= pwdata[BYTES_W-1:0];
                    default:        ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_comb begin
        case (w_index)
            REG_DIM0:       prdata = DATA_W'(r_dim[0]);
            REG_DIM1:       prdata = DATA_W'(r_dim[1]);
            REG_DIM2:       prdata = DATA_W'(r_dim[2]);
            REG_DIM3:       prdata = DATA_W'(r_dim[3]);
            REG_AXIS_ORDER: prdata = DATA_W'(r_order);
            REG_ELEM_BYTES: prdata = DATA_W'(r_bytes);
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/tpag_front.sv -----
module tpag_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_restart,
    input  tpag_pkg::t_geom   i_geom,
    input  logic              i_full,
    output logic              o_push,
    output tpag_pkg::t_entry  o_entry
);
    import tpag_pkg::*;

    logic [NUM_AXES-1:0][COORD_W-1:0] r_coord;
    logic [IDX_W-1:0]                 r_dst;

    logic [NUM_AXES-1:0][COORD_W-1:0] w_base;
    logic [IDX_W-1:0]                 w_base_dst;
    logic [NUM_AXES-1:0][COORD_W-1:0] n_coord;
    logic [IDX_W-1:0]                 n_dst;
    logic [NUM_AXES-1:0]              w_room;
    logic                             w_last;
    logic                             w_carry;

    assign o_in_ready = !i_full && !i_geom.busy;
    assign o_push     = i_in_valid && o_in_ready;

    assign w_base     = i_restart ? '0 : r_coord;
    assign w_base_dst = i_restart ? '0 : r_dst;

    // An axis has room when its coordinate is short of the end; a
    // coordinate at or past the end wraps to zero on a carry.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_room[k] = ({1'b0, w_base[k]} + 13'd1) < i_geom.odim[k];
        end
    end

    assign w_last = (w_room == '0);

    always_comb begin
        w_carry = 1'b1;
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            if (w_carry) begin
                if (w_room[k]) begin
                    n_coord[k] = w_base[k] + 12'd1;
                    w_carry    = 1'b0;
                end else begin
                    n_coord[k] = '0;
                end
            end else begin
                n_coord[k] = w_base[k];
            end
        end
    end

    assign n_dst = w_last ? '0 : w_base_dst + 48'd1;

    assign o_entry.coord = w_base;
    assign o_entry.dst   = w_base_dst;
    assign o_entry.last  = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_dst   <= '0;
        end else if (o_push) begin
            r_coord <= n_coord;
            r_dst   <= n_dst;
        end
    end

endmodule

// ----- rtl/core/tpag_fifo.sv -----
module tpag_fifo #(
    parameter int DEPTH = tpag_pkg::Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpag_pkg::t_entry  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output tpag_pkg::t_entry  o_data,
    output logic              o_empty
);
    import tpag_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/tpag_back.sv -----
module tpag_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  tpag_pkg::t_entry             i_entry,
    input  tpag_pkg::t_geom              i_geom,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tpag_pkg::IDX_W-1:0]   o_dst_index,
    output logic [tpag_pkg::IDX_W-1:0]   o_src_index,
    output logic [tpag_pkg::BYTE_W-1:0]  o_dst_byte_offset,
    output logic [tpag_pkg::BYTE_W-1:0]  o_src_byte_offset,
    output logic                         o_last
);
    import tpag_pkg::*;

    localparam int PROD_W = COORD_W + STRIDE_W;

    // Stage 1: one coordinate times stride per axis.
    logic                           r_v1;
    logic [NUM_AXES-1:0][IDX_W-1:0] r_prod;
    logic [IDX_W-1:0]               r_dst1;
    logic                           r_last1;
    // Stage 2: pairwise sums.
    logic                           r_v2;
    logic [IDX_W-1:0]               r_sum_lo;
    logic [IDX_W-1:0]               r_sum_hi;
    logic [IDX_W-1:0]               r_dst2;
    logic                           r_last2;
    // Stage 3: source index.
    logic                           r_v3;
    logic [IDX_W-1:0]               r_src3;
    logic [IDX_W-1:0]               r_dst3;
    logic                           r_last3;
    // Stage 4: byte offsets, the output register.
    logic                           r_v4;
    logic [IDX_W-1:0]               r_src4;
    logic [IDX_W-1:0]               r_dst4;
    logic [BYTE_W-1:0]              r_src_bytes;
    logic [BYTE_W-1:0]              r_dst_bytes;
    logic                           r_last4;

    logic                           w_en1;
    logic                           w_en2;
    logic                           w_en3;
    logic                           w_en4;
    logic [NUM_AXES-1:0][PROD_W-1:0] w_prod;

    // A stage moves when it is empty or the stage after it moves.
    assign w_en4   = !r_v4 || i_out_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            w_prod[j] = i_entry.coord[j] * i_geom.ostride[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_prod[j] <= w_prod[j][IDX_W-1:0];
            end
            r_dst1  <= i_entry.dst;
            r_last1 <= i_entry.last;
        end
        if (w_en2 && r_v1) begin
            r_sum_lo <= r_prod[0] + r_prod[1];
            r_sum_hi <= r_prod[2] + r_prod[3];
            r_dst2   <= r_dst1;
            r_last2  <= r_last1;
        end
        if (w_en3 && r_v2) begin
            r_src3  <= r_sum_lo + r_sum_hi;
            r_dst3  <= r_dst2;
            r_last3 <= r_last2;
        end
        if (w_en4 && r_v3) begin
            r_src4      <= r_src3;
            r_dst4      <= r_dst3;
            r_src_bytes <= BYTE_W'(r_src3) * BYTE_W'(i_geom.bytes);
            r_dst_bytes <= BYTE_W'(r_dst3) * BYTE_W'(i_geom.bytes);
            r_last4     <= r_last3;
        end
    end

    assign o_out_valid       = r_v4;
    assign o_dst_index       = r_dst4;
    assign o_src_index       = r_src4;
    assign o_dst_byte_offset = r_dst_bytes;
    assign o_src_byte_offset = r_src_bytes;
    assign o_last            = r_last4;

endmodule

// ----- test/tb_tensor_permute_address_gen.sv -----
module tb_tensor_permute_address_gen;
    timeunit 1ns;
    timeprecision 1ps;

    import tpag_pkg::*;

    typedef enum logic {ROW_WRITE, ROW_BEAT} t_row_kind;

    typedef struct packed {
        logic [IDX_W-1:0]  dst_index;
        logic [IDX_W-1:0]  src_elem;
        logic [BYTE_W-1:0] dst_byte_offset;
        logic [BYTE_W-1:0] src_byte_offset;
        logic              last;
    } t_addr_rec;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_idx    idx;
        logic [31:0] value;
        logic        restart;
        logic        known;
        t_addr_rec   want;
    } t_row;

    localparam int DIM_MAX     = 4096;
    localparam int BYTES_MAX   = 8;
    localparam int IDLE_PCT    = 17;
    localparam int RAND_ITEMS  = 600;
    localparam int CALM_ITEMS  = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;

    localparam logic [ORDER_W-1:0] ORDER_IDENTITY   = 8'hE4;
    localparam logic [ORDER_W-1:0] ORDER_REVERSE    = 8'h1B;
    localparam logic [ORDER_W-1:0] ORDER_ALL_OUTER  = 8'h00;
    localparam logic [ORDER_W-1:0] ORDER_ALL_SECOND = 8'h55;

    localparam t_addr_rec NO_ADDR = '0;
    localparam t_addr_rec ZERO_LAST = '{dst_index: '0, src_elem: '0, dst_byte_offset: '0,
                                        src_byte_offset: '0, last: 1'b1};
    localparam t_addr_rec ZERO_FIRST = '{dst_index: '0, src_elem: '0, dst_byte_offset: '0,
                                         src_byte_offset: '0, last: 1'b0};

    localparam int N_ROWS = 42;
    localparam t_row DIRECTED [N_ROWS] = '{
        // Reset geometry is a single element, so every beat is element zero and last.
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b1, ZERO_LAST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b1, 1'b1, ZERO_LAST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b1, ZERO_LAST},
        '{ROW_WRITE, REG_DIM0,       32'd2,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM1,       32'd3,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM2,       32'd1,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM3,       32'd4,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_AXIS_ORDER, 32'(ORDER_REVERSE),    1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_ELEM_BYTES, 32'd8,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b1, 1'b1, ZERO_FIRST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b1, 1'b1, ZERO_FIRST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        // Clamped sizes and a duplicated order, written mid-walk: the stale coordinates
        // sit at or past the end of every axis, so the next beat is last.
        '{ROW_WRITE, REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM1,       32'd8191,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM2,       32'd4097,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM3,       32'd1,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_AXIS_ORDER, 32'(ORDER_ALL_OUTER),  1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_ELEM_BYTES, 32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b1, ZERO_LAST},
        '{ROW_WRITE, REG_AXIS_ORDER, 32'(ORDER_ALL_SECOND), 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_ELEM_BYTES, 32'd15,                1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b1, 1'b1, ZERO_FIRST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM0,       32'd4096,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM1,       32'd4096,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM2,       32'd4096,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_DIM3,       32'd4096,              1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_AXIS_ORDER, 32'(ORDER_IDENTITY),   1'b0, 1'b0, NO_ADDR},
        '{ROW_WRITE, REG_ELEM_BYTES, 32'd1,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b1, 1'b1, ZERO_FIRST},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR},
        '{ROW_BEAT,  REG_DIM0,       32'd0,                 1'b0, 1'b0, NO_ADDR}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_restart;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [IDX_W-1:0]   o_dst_index;
    logic [IDX_W-1:0]   o_src_index;
    logic [BYTE_W-1:0]  o_dst_byte_offset;
    logic [BYTE_W-1:0]  o_src_byte_offset;
    logic               o_last;

    // Shadow of the registers and of the walk position.
    logic [DIM_W-1:0]   cfg_dim [NUM_AXES];
    logic [ORDER_W-1:0] cfg_order;
    logic [BYTES_W-1:0] cfg_bytes;
    logic [COORD_W-1:0] walk_coord [NUM_AXES];
    logic [IDX_W-1:0]   walk_count;

    t_addr_rec due_addrs [$];
    int  n_err = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_last = 0;
    int  n_writes = 0;
    int  stall_cycles = 0;
    bit  calm = 1'b0;

    tensor_permute_address_gen u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_dst_index       (o_dst_index),
        .o_src_index       (o_src_index),
        .o_dst_byte_offset (o_dst_byte_offset),
        .o_src_byte_offset (o_src_byte_offset),
        .o_last            (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] eff_axis(input int a);
        logic [63:0] d;
        if (a < NUM_AXES - MAX_RANK) return 64'd1;
        d = 64'(cfg_dim[a]);
        if (d == 0) return 64'd1;
        if (d > DIM_MAX) return 64'(DIM_MAX);
        return d;
    endfunction

    // Addresses of the current output element; moves the walk one element on.
    function automatic t_addr_rec walk_next_addr(input logic restart);
        logic [63:0] idim [NUM_AXES];
        logic [63:0] istride [NUM_AXES];
        logic [63:0] odim [NUM_AXES];
        logic [63:0] span;
        logic [63:0] acc;
        logic [63:0] scale;
        logic [63:0] prod;
        logic [1:0]  a;
        logic        is_last;
        t_addr_rec   rec;
        if (restart) begin
            foreach (walk_coord[k]) walk_coord[k] = '0;
            walk_count = '0;
        end
        for (int k = 0; k < NUM_AXES; k++) idim[k] = eff_axis(k);
        span = 64'd1;
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            istride[k] = span;
            span = span * idim[k];
        end
        acc = '0;
        is_last = 1'b1;
        for (int j = 0; j < NUM_AXES; j++) begin
            a = cfg_order[2*j +: 2];
            odim[j] = idim[a];
            acc = acc + 64'(walk_coord[j]) * istride[a];
            if (64'(walk_coord[j]) + 64'd1 < odim[j]) is_last = 1'b0;
        end
        if (cfg_bytes == 0) scale = 64'd1;
        else if (cfg_bytes > BYTES_MAX) scale = 64'(BYTES_MAX);
        else scale = 64'(cfg_bytes);
        rec.dst_index = walk_count;
        rec.src_elem = acc[IDX_W-1:0];
        prod = 64'(walk_count) * scale;
        rec.dst_byte_offset = prod[BYTE_W-1:0];
        prod = 64'(rec.src_elem) * scale;
        rec.src_byte_offset = prod[BYTE_W-1:0];
        rec.last = is_last;
        if (is_last) begin
            foreach (walk_coord[k]) walk_coord[k] = '0;
            walk_count = '0;
        end else begin
            // Carry from the innermost axis; a coordinate at or past its end wraps to 0.
            for (int k = NUM_AXES - 1; k >= 0; k--) begin
                if (64'(walk_coord[k]) + 64'd1 < odim[k]) begin
                    walk_coord[k] = walk_coord[k] + 1'b1;
                    break;
                end
                walk_coord[k] = '0;
            end
            walk_count = walk_count + 1'b1;
        end
        return rec;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(99) >= 8) return DIM_W'($urandom_range(1, 4));
        case ($urandom_range(4))
            0: return '0;
            1: return DIM_W'(DIM_MAX);
            2: return DIM_W'(DIM_MAX + 1);
            3: return '1;
            default: return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
        endcase
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] keep;
        logic [31:0] data;
        if (idx == REG_AXIS_ORDER) keep = (32'd1 << ORDER_W) - 1;
        else if (idx == REG_ELEM_BYTES) keep = (32'd1 << BYTES_W) - 1;
        else keep = (32'd1 << DIM_W) - 1;
        data = value;
        // Now and then set the unused upper bits; they must be dropped.
        if ($urandom_range(3) == 0) data = data | ($urandom & ~keep);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3: cfg_dim[idx] = data[DIM_W-1:0];
            REG_AXIS_ORDER: cfg_order = data[ORDER_W-1:0];
            default:        cfg_bytes = data[BYTES_W-1:0];
        endcase
        n_writes++;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_addrs.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic restart, input logic known, input t_addr_rec typed);
        t_addr_rec calc;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        calc = walk_next_addr(restart);
        due_addrs.push_back(known ? typed : calc);
        n_in++;
    endtask

    task automatic write_config(input logic [DIM_W-1:0] d0, input logic [DIM_W-1:0] d1,
                                input logic [DIM_W-1:0] d2, input logic [DIM_W-1:0] d3,
                                input logic [ORDER_W-1:0] order,
                                input logic [BYTES_W-1:0] bytes);
        wait_drained();
        apb_write(REG_DIM0, 32'(d0));
        apb_write(REG_DIM1, 32'(d1));
        apb_write(REG_DIM2, 32'(d2));
        apb_write(REG_DIM3, 32'(d3));
        apb_write(REG_AXIS_ORDER, 32'(order));
        apb_write(REG_ELEM_BYTES, 32'(bytes));
        apb_release();
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_out
        t_addr_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_addrs.size() == 0) begin
                $display("%0t: output beat with nothing outstanding, dst_index %h",
                         $time, o_dst_index);
                n_err++;
            end else begin
                want = due_addrs.pop_front();
                check_field("dst_index", BYTE_W'(want.dst_index), BYTE_W'(o_dst_index));
                check_field("src_elem", BYTE_W'(want.src_elem), BYTE_W'(o_src_index));
                check_field("dst_byte_offset", want.dst_byte_offset, o_dst_byte_offset);
                check_field("src_byte_offset", want.src_byte_offset, o_src_byte_offset);
                check_field("last", BYTE_W'(want.last), BYTE_W'(o_last));
                n_out++;
                if (o_last) n_last++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stim
        int r;
        int k;
        int len;
        int n_rand;
        logic [DIM_W-1:0] d [NUM_AXES];
        foreach (cfg_dim[i]) cfg_dim[i] = DIM_W'(1);
        cfg_order = ORDER_IDENTITY;
        cfg_bytes = BYTES_W'(4);
        foreach (walk_coord[i]) walk_coord[i] = '0;
        walk_count = '0;
        n_rand = 0;

        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_restart  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                wait_drained();
                apb_write(DIRECTED[r].idx, DIRECTED[r].value);
                if (r + 1 == N_ROWS || DIRECTED[r + 1].kind != ROW_WRITE) apb_release();
            end else begin
                send_beat(DIRECTED[r].restart, DIRECTED[r].known, DIRECTED[r].want);
            end
        end

        // Every output axis reads the outermost input axis of a full-size
        // tensor, so the source index climbs by the largest stride and the source
        // byte offset reaches its upper bits. Neither side idles here.
        calm <= 1'b1;
        write_config(DIM_W'(DIM_MAX), DIM_W'(DIM_MAX), DIM_W'(DIM_MAX), DIM_W'(DIM_MAX),
                     ORDER_ALL_OUTER, BYTES_W'(BYTES_MAX));
        send_beat(1'b1, 1'b0, NO_ADDR);
        repeat (CALM_ITEMS - 1) send_beat(1'b0, 1'b0, NO_ADDR);
        calm <= 1'b0;

        // Random shapes, mostly small so the walk wraps often. About half the phases
        // carry on from the coordinates the previous shape left behind.
        while (n_rand < RAND_ITEMS) begin
            for (k = 0; k < NUM_AXES; k++) d[k] = pick_dim();
            write_config(d[0], d[1], d[2], d[3], ORDER_W'($urandom_range(255)),
                         BYTES_W'($urandom_range(15)));
            len = $urandom_range(30, 80);
            for (k = 0; k < len; k++) begin
                send_beat((k == 0 && $urandom_range(1) == 1) || $urandom_range(99) < 4,
                          1'b0, NO_ADDR);
            end
            n_rand += len;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d advance beats and checked %0d address beats (%0d flagged last)",
                 n_in, n_out, n_last);
        $display("over %0d register writes: clamped sizes, duplicate orders, large strides",
                 n_writes);
        if (n_err == 0 && due_addrs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
